// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the block allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/fbfla_pkg.sv =====
// Types and constants of the fixed block free-list allocator
`timescale 1ns / 1ps

package fbfla_pkg;

    localparam int ADDR_W     = 48;
    localparam int OFS_W      = 16;
    localparam int STRIDE_W   = 16;
    localparam int BLK_W      = 11;
    localparam int SLOT_W     = 10;
    localparam int STAT_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_STEP   = 2;   // quotient bits per divider cycle

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POOL_BASE      = 3'd0,
        CFG_PAYLOAD_OFFSET = 3'd1,
        CFG_BLOCK_STRIDE   = 3'd2,
        CFG_BLOCKS_IN_USE  = 3'd3,
        CFG_STORAGE_BYTES  = 3'd4
    } t_cfg_idx;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_INVALID = 3'd2,
        ST_DOUBLE  = 3'd3,
        ST_NULL    = 3'd4
    } t_status;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic [SLOT_W-1:0] slot;
        logic [STAT_W-1:0] status;
        logic [BLK_W-1:0]  free_left;
    } t_rsp;

    typedef struct packed {
        logic                start;
        logic [ADDR_W-1:0]   dividend;
        logic [STRIDE_W-1:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic                done;
        logic [ADDR_W-1:0]   quotient;
        logic [STRIDE_W-1:0] remainder;
    } t_div_res;

endpackage

// ===== rtl/fbfla_req_if.sv =====
// Request channel interface: op and address word
`timescale 1ns / 1ps

interface fbfla_req_if;
    import fbfla_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fbfla_rsp_if.sv =====
// Response channel interface: allocation result word
`timescale 1ns / 1ps

interface fbfla_rsp_if;
    import fbfla_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/fbfla_ram.sv =====
// Generic single-clock RAM, one write port, one registered read port
`timescale 1ns / 1ps

module fbfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fbfla_div.sv =====
// Iterative restoring divider: address offset by block stride
`timescale 1ns / 1ps

module fbfla_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbfla_pkg::t_div_cmd i_cmd,
    output fbfla_pkg::t_div_res o_res
);
    import fbfla_pkg::*;

    localparam int ITERS = ADDR_W / DIV_STEP;
    localparam int CNT_W = $clog2(ITERS + 1);

    logic                r_busy, n_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [ADDR_W-1:0]   r_quot, n_quot;
    logic [STRIDE_W-1:0] r_rem, n_rem;
    logic [STRIDE_W-1:0] r_div;
    logic [STRIDE_W:0]   v_trial;

    always_comb begin
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_quot  = r_quot;
        n_rem   = r_rem;
        v_trial = '0;
        if (i_cmd.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(ITERS);
            n_quot = i_cmd.dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            for (int k = 0; k < DIV_STEP; k++) begin
                v_trial = {n_rem, n_quot[ADDR_W-1]};
                n_quot  = {n_quot[ADDR_W-2:0], 1'b0};
                if (v_trial >= {1'b0, r_div}) begin
                    v_trial   = v_trial - {1'b0, r_div};
                    n_quot[0] = 1'b1;
                end
                n_rem = v_trial[STRIDE_W-1:0];
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= r_busy && !i_cmd.start && (r_cnt == CNT_W'(1));
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_cmd.start) begin
            r_div <= i_cmd.divisor;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.quotient  = r_quot;
    assign o_res.remainder = r_rem;

endmodule

// ===== rtl/fixed_block_free_list_allocator.sv =====
// Top level of the fixed block free-list allocator
// Usage:
//   i_req carries one word per request: op 0 allocates a block, op 1 frees the
//   payload address in address. o_rsp returns one word per request with the
//   payload address, slot, status and the free block count after it.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the
//   user must do so only while the block is idle, unchecked by the block.
//   Writing blocks_in_use reinitializes the free list. One request is in work
//   at a time: an allocate passes S_ALC_LINK (freed list only), S_ALC_MUL,
//   S_ALC_ADD and S_DONE; a failed allocate or null free goes to S_DONE; a
//   free passes S_FRE_CHK1, S_FRE_CHK2, a 2-bit-per-cycle divider over the
//   48-bit offset and S_FRE_UPD, skipping the divider on a range refusal and
//   S_FRE_UPD on a remainder or quotient refusal; the divider sets the free
//   request rate. Block links and allocated flags sit in one MAX_BLOCKS-deep
//   RAM. After reset and each blocks_in_use write, a clearing pass sweeps
//   that RAM; i_req.ready stays low meanwhile. A finished word waits in the
//   output register while o_rsp.ready is low; the next request is accepted
//   and worked on, but its word is held back until the register empties.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fixed_block_free_list_allocator #(
    parameter int MAX_BLOCKS = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    fbfla_req_if.sink                             i_req,
    fbfla_rsp_if.source                           o_rsp,
    input  logic                                  i_cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    import fbfla_pkg::*;

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int EW = (CW > BLK_W) ? CW : BLK_W;
    localparam int MW = IW + 1;
    localparam int PW = IW + STRIDE_W;

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_ALC_LINK = 10'b00_0000_0100,
        S_ALC_MUL  = 10'b00_0000_1000,
        S_ALC_ADD  = 10'b00_0001_0000,
        S_FRE_CHK1 = 10'b00_0010_0000,
        S_FRE_CHK2 = 10'b00_0100_0000,
        S_FRE_DIV  = 10'b00_1000_0000,
        S_FRE_UPD  = 10'b01_0000_0000,
        S_DONE     = 10'b10_0000_0000
    } t_state;

    function automatic logic [CW-1:0] eff_of(input logic [BLK_W-1:0] b);
        if (EW'(b) > EW'(MAX_BLOCKS)) begin
            return CW'(MAX_BLOCKS);
        end
        return CW'(b);
    endfunction

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_pool_base, n_pool_base;
    logic [OFS_W-1:0]    r_payload_ofs, n_payload_ofs;
    logic [STRIDE_W-1:0] r_stride, n_stride;
    logic [BLK_W-1:0]    r_blocks, n_blocks;
    logic [ADDR_W-1:0]   r_storage, n_storage;

    logic [IW-1:0]       r_head, n_head;
    logic                r_head_vld, n_head_vld;
    logic [CW-1:0]       r_list_len, n_list_len;
    logic [CW-1:0]       r_fresh, n_fresh;
    logic [CW-1:0]       r_free_total, n_free_total;
    logic [IW-1:0]       r_clr_cnt, n_clr_cnt;

    logic [ADDR_W-1:0]   r_addr, n_addr;
    logic [IW-1:0]       r_slot, n_slot;
    t_status             r_status, n_status;
    logic [PW-1:0]       r_prod, n_prod;
    logic [ADDR_W-1:0]   r_payload, n_payload;
    logic [ADDR_W:0]     r_lim, n_lim;
    logic [ADDR_W:0]     r_off, n_off;

    logic                r_out_valid, n_out_valid;
    t_rsp                r_out, n_out;

    logic [CW-1:0]       v_eff;
    logic [ADDR_W:0]     v_rel;
    logic                v_we;
    logic [IW-1:0]       v_waddr;
    logic [MW-1:0]       v_wdata;
    logic [IW-1:0]       v_raddr;
    logic [MW-1:0]       v_rdata;
    t_div_cmd            v_div_cmd;
    t_div_res            v_div_res;

    // entry: [IW] allocated flag, [IW-1:0] link to next freed block
    fbfla_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (v_wdata),
        .i_raddr (v_raddr),
        .o_rdata (v_rdata)
    );

    fbfla_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (v_div_cmd),
        .o_res   (v_div_res)
    );

    always_comb begin
        v_eff = eff_of(r_blocks);
        v_rel = {1'b0, r_off[ADDR_W-1:0]} - {{(ADDR_W-OFS_W+1){1'b0}}, r_payload_ofs};

        n_state       = r_state;
        n_pool_base   = r_pool_base;
        n_payload_ofs = r_payload_ofs;
        n_stride      = r_stride;
        n_blocks      = r_blocks;
        n_storage     = r_storage;
        n_head        = r_head;
        n_head_vld    = r_head_vld;
        n_list_len    = r_list_len;
        n_fresh       = r_fresh;
        n_free_total  = r_free_total;
        n_clr_cnt     = r_clr_cnt;
        n_addr        = r_addr;
        n_slot        = r_slot;
        n_status      = r_status;
        n_prod        = r_prod;
        n_payload     = r_payload;
        n_lim         = r_lim;
        n_off         = r_off;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        v_we      = 1'b0;
        v_waddr   = r_slot;
        v_wdata   = '0;
        v_raddr   = r_head;
        v_div_cmd = '0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                v_we    = 1'b1;
                v_waddr = r_clr_cnt;
                if (r_clr_cnt == IW'(MAX_BLOCKS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_addr    = i_req.data.address;
                    n_slot    = '0;
                    n_payload = '0;
                    n_status  = ST_OK;
                    if (i_req.data.op == OP_FREE) begin
                        if (i_req.data.address == '0) begin
                            n_status = ST_NULL;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_FRE_CHK1;
                        end
                    end else if (r_list_len != '0) begin
                        // head entry read issued now
                        n_slot  = r_head;
                        n_state = S_ALC_LINK;
                    end else if (r_fresh < v_eff) begin
                        n_slot       = r_fresh[IW-1:0];
                        v_we         = 1'b1;
                        v_waddr      = r_fresh[IW-1:0];
                        v_wdata      = {1'b1, {IW{1'b0}}};
                        n_fresh      = r_fresh + 1'b1;
                        n_free_total = r_free_total - 1'b1;
                        n_state      = S_ALC_MUL;
                    end else begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end
                end
            end
            S_ALC_LINK: begin
                v_we    = 1'b1;
                v_waddr = r_slot;
                v_wdata = {1'b1, {IW{1'b0}}};
                if (r_list_len > CW'(1)) begin
                    n_head = v_rdata[IW-1:0];
                end else begin
                    n_head_vld = 1'b0;
                end
                n_list_len   = r_list_len - 1'b1;
                n_free_total = r_free_total - 1'b1;
                n_state      = S_ALC_MUL;
            end
            S_ALC_MUL: begin
                n_prod  = r_slot * r_stride;
                n_state = S_ALC_ADD;
            end
            S_ALC_ADD: begin
                n_payload = r_pool_base + ADDR_W'(r_prod) + ADDR_W'(r_payload_ofs);
                n_state   = S_DONE;
            end
            S_FRE_CHK1: begin
                n_lim   = {1'b0, r_pool_base} + {1'b0, r_storage};
                n_off   = {1'b0, r_addr} - {1'b0, r_pool_base};
                n_state = S_FRE_CHK2;
            end
            S_FRE_CHK2: begin
                if ((r_stride != '0) && !r_off[ADDR_W] && ({1'b0, r_addr} < r_lim)
                    && !v_rel[ADDR_W]) begin
                    v_div_cmd.start    = 1'b1;
                    v_div_cmd.dividend = v_rel[ADDR_W-1:0];
                    v_div_cmd.divisor  = r_stride;
                    n_state            = S_FRE_DIV;
                end else begin
                    n_status = ST_INVALID;
                    n_state  = S_DONE;
                end
            end
            S_FRE_DIV: begin
                v_raddr = v_div_res.quotient[IW-1:0];
                if (v_div_res.done) begin
                    if ((v_div_res.remainder == '0)
                        && (v_div_res.quotient < ADDR_W'(v_eff))) begin
                        n_slot  = v_div_res.quotient[IW-1:0];
                        n_state = S_FRE_UPD;
                    end else begin
                        n_status = ST_INVALID;
                        n_state  = S_DONE;
                    end
                end
            end
            S_FRE_UPD: begin
                if (!v_rdata[IW]) begin
                    n_status = ST_DOUBLE;
                end else begin
                    v_we         = 1'b1;
                    v_waddr      = r_slot;
                    v_wdata      = {1'b0, (r_head_vld ? r_head : {IW{1'b0}})};
                    n_head       = r_slot;
                    n_head_vld   = 1'b1;
                    n_list_len   = r_list_len + 1'b1;
                    n_free_total = r_free_total + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid           = 1'b1;
                    n_out.payload_address = r_payload;
                    n_out.slot            = SLOT_W'(r_slot);
                    n_out.status          = r_status;
                    n_out.free_left       = BLK_W'(r_free_total);
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POOL_BASE:      n_pool_base   = i_cfg_wdata[ADDR_W-1:0];
                CFG_PAYLOAD_OFFSET: n_payload_ofs = i_cfg_wdata[OFS_W-1:0];
                CFG_BLOCK_STRIDE:   n_stride      = i_cfg_wdata[STRIDE_W-1:0];
                CFG_BLOCKS_IN_USE: begin
                    n_blocks     = i_cfg_wdata[BLK_W-1:0];
                    n_head_vld   = 1'b0;
                    n_list_len   = '0;
                    n_fresh      = '0;
                    n_free_total = eff_of(i_cfg_wdata[BLK_W-1:0]);
                    n_clr_cnt    = '0;
                    n_state      = S_CLEAR;
                end
                CFG_STORAGE_BYTES:  n_storage     = i_cfg_wdata[ADDR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_pool_base   <= '0;
            r_payload_ofs <= '0;
            r_stride      <= STRIDE_W'(16);
            r_blocks      <= BLK_W'(1024);
            r_storage     <= ADDR_W'(16384);
            r_head        <= '0;
            r_head_vld    <= 1'b0;
            r_list_len    <= '0;
            r_fresh       <= '0;
            r_free_total  <= eff_of(BLK_W'(1024));
            r_clr_cnt     <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pool_base   <= n_pool_base;
            r_payload_ofs <= n_payload_ofs;
            r_stride      <= n_stride;
            r_blocks      <= n_blocks;
            r_storage     <= n_storage;
            r_head        <= n_head;
            r_head_vld    <= n_head_vld;
            r_list_len    <= n_list_len;
            r_fresh       <= n_fresh;
            r_free_total  <= n_free_total;
            r_clr_cnt     <= n_clr_cnt;
            r_out_valid   <= n_out_valid;
        end
        r_addr    <= n_addr;
        r_slot    <= n_slot;
        r_status  <= n_status;
        r_prod    <= n_prod;
        r_payload <= n_payload;
        r_lim     <= n_lim;
        r_off     <= n_off;
        r_out     <= n_out;
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    `ASSERT_ALWAYS(a_head_matches_len, i_clk, i_rst_n, r_head_vld == (r_list_len != '0))
    `ASSERT_ALWAYS(a_free_count, i_clk, i_rst_n, r_free_total == (r_list_len + (v_eff - r_fresh)))
    `ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state != S_IDLE)

endmodule
